>>> hw/rtl/limit_order_book_add_cancel_unit_defines.svh
// ----------------------------------------------------------------------------
// order book assertion macros
// shared property forms for the order book unit
// ----------------------------------------------------------------------------
`ifndef LIMIT_ORDER_BOOK_ADD_CANCEL_UNIT_DEFINES_SVH
`define LIMIT_ORDER_BOOK_ADD_CANCEL_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LOBAC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LOBAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lobac_pkg.sv
// ----------------------------------------------------------------------------
// order book package
// sizes, result codes and the command and status groups of the unit
// ----------------------------------------------------------------------------
package lobac_pkg;

    // book geometry
    localparam int LEVEL_SLOTS    = 64;
    localparam int LEVEL_DEPTH    = 16;
    localparam int ORDER_CAPACITY = 256;

    localparam int NSLOTS = 2 * LEVEL_SLOTS;
    localparam int EntW   = (ORDER_CAPACITY > 1) ? $clog2(ORDER_CAPACITY) : 1;
    localparam int SlotW  = (LEVEL_SLOTS > 1) ? $clog2(LEVEL_SLOTS) : 1;
    localparam int GW     = SlotW + 1;
    localparam int PosW   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CntW   = $clog2(LEVEL_DEPTH + 1);
    localparam int RestAW = GW + PosW;
    localparam int ScMax  = (ORDER_CAPACITY > LEVEL_SLOTS) ? ORDER_CAPACITY : LEVEL_SLOTS;
    localparam int ScW    = $clog2(ScMax + 1);

    // result codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_NOT_LIMIT = 4'd1;
    localparam logic [3:0] ST_DUP_ID    = 4'd2;
    localparam logic [3:0] ST_BAD_QTY   = 4'd3;
    localparam logic [3:0] ST_BAD_PRICE = 4'd4;
    localparam logic [3:0] ST_NOT_FOUND = 4'd5;
    localparam logic [3:0] ST_STALE     = 4'd6;
    localparam logic [3:0] ST_LVL_FULL  = 4'd7;
    localparam logic [3:0] ST_BOOK_FULL = 4'd8;

    localparam logic [1:0] TYPE_LIMIT = 2'd0;
    localparam logic       ACT_CANCEL = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       scan_clr;
        logic       scan;
        logic       scan_slot;
        logic       rd_ent;
        logic       rd_cnt;
        logic       wr_add;
        logic       clr_ent;
        logic       sh_rd;
        logic       sh_wr;
        logic       fin;
        logic       emit;
        logic [3:0] code;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_cancel;
        logic bad_type;
        logic bad_qty;
        logic bad_price;
        logic scan_done;
        logic id_hit;
        logic free_ent;
        logic lvl_hit;
        logic free_slot;
        logic lvl_full;
        logic stale;
        logic more;
    } t_stat;

    // one resting order
    typedef struct packed {
        logic [EntW-1:0] ent;
        logic [31:0]     qty;
        logic [31:0]     id;
    } t_rest;

endpackage

>>> hw/rtl/limit_order_book_add_cancel_unit.sv
// ----------------------------------------------------------------------------
// limit order book add/cancel unit
// two-sided price-level book with per-level fifo queues and an order index
// ----------------------------------------------------------------------------
// One item is taken when start is high and busy is low; busy then stays high
// until the result is shown on o_status, o_queue_position and
// o_level_removed for exactly one cycle with o_valid, which must be captured
// then since the result cannot be held. The next item can be taken at the
// edge that ends the result cycle. Every item first walks the order index
// one entry a cycle and then decides. Rejected adds and unknown cancels end
// there. An add that passes then walks its side's level table, then reads
// and checks the level count and writes the order if it fits. A cancel
// reads its index entry and level count, then shifts each order behind it in
// its queue up by one place, each queue shift using one read and one write of
// the resting order memory. No clearing pass is needed after reset.
module limit_order_book_add_cancel_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [31:0]        i_order_id,
    input  logic [1:0]         i_order_type,
    input  logic               i_side,
    input  logic signed [31:0] i_price,
    input  logic signed [31:0] i_quantity,
    output logic               o_valid,
    output logic [3:0]         o_status,
    output logic [3:0]         o_queue_position,
    output logic               o_level_removed
);

    lobac_pkg::t_cmd  cmd;
    lobac_pkg::t_stat stat;

    // sequencer
    lobac_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // book storage and compare logic
    lobac_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_action         (i_action),
        .i_order_id       (i_order_id),
        .i_order_type     (i_order_type),
        .i_side           (i_side),
        .i_price          (i_price),
        .i_quantity       (i_quantity),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_queue_position (o_queue_position),
        .o_level_removed  (o_level_removed)
    );

endmodule

>>> hw/rtl/lobac_ctrl.sv
// ----------------------------------------------------------------------------
// order book controller
// sequences index scan, level scan, update and queue shift per item
// ----------------------------------------------------------------------------
module lobac_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  lobac_pkg::t_stat i_stat,
    output lobac_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN_ID = 3'd1;
    localparam logic [2:0] S_DECIDE  = 3'd2;
    localparam logic [2:0] S_SCAN_SL = 3'd3;
    localparam logic [2:0] S_RD_CNT  = 3'd4;
    localparam logic [2:0] S_CHK_CNT = 3'd5;
    localparam logic [2:0] S_SH_TEST = 3'd6;
    localparam logic [2:0] S_SH_WR   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign busy = (r_state != S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN_ID;
                end
            end
            S_SCAN_ID: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.is_cancel) begin
                    if (!i_stat.id_hit) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.code = lobac_pkg::ST_NOT_FOUND;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.rd_ent = 1'b1;
                        n_state      = S_RD_CNT;
                    end
                end else if (i_stat.bad_type || i_stat.id_hit || i_stat.bad_qty
                             || i_stat.bad_price) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                    if (i_stat.bad_type) begin
                        o_cmd.code = lobac_pkg::ST_NOT_LIMIT;
                    end else if (i_stat.id_hit) begin
                        o_cmd.code = lobac_pkg::ST_DUP_ID;
                    end else if (i_stat.bad_qty) begin
                        o_cmd.code = lobac_pkg::ST_BAD_QTY;
                    end else begin
                        o_cmd.code = lobac_pkg::ST_BAD_PRICE;
                    end
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN_SL;
                end
            end
            S_SCAN_SL: begin
                o_cmd.scan      = 1'b1;
                o_cmd.scan_slot = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_RD_CNT;
                end
            end
            S_RD_CNT: begin
                o_cmd.rd_cnt = 1'b1;
                n_state      = S_CHK_CNT;
            end
            S_CHK_CNT: begin
                n_state = S_IDLE;
                if (i_stat.is_cancel) begin
                    o_cmd.clr_ent = 1'b1;
                    if (i_stat.stale) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.code = lobac_pkg::ST_STALE;
                    end else begin
                        n_state = S_SH_TEST;
                    end
                end else begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.lvl_full) begin
                        o_cmd.code = lobac_pkg::ST_LVL_FULL;
                    end else if ((!i_stat.lvl_hit && !i_stat.free_slot)
                                 || !i_stat.free_ent) begin
                        o_cmd.code = lobac_pkg::ST_BOOK_FULL;
                    end else begin
                        o_cmd.code   = lobac_pkg::ST_OK;
                        o_cmd.wr_add = 1'b1;
                    end
                end
            end
            S_SH_TEST: begin
                if (i_stat.more) begin
                    o_cmd.sh_rd = 1'b1;
                    n_state     = S_SH_WR;
                end else begin
                    o_cmd.fin  = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.code = lobac_pkg::ST_OK;
                    n_state    = S_IDLE;
                end
            end
            S_SH_WR: begin
                o_cmd.sh_wr = 1'b1;
                n_state     = S_SH_TEST;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/lobac_dp.sv
// ----------------------------------------------------------------------------
// order book datapath
// order index, price level table and resting queues with their scan logic
// ----------------------------------------------------------------------------
`include "limit_order_book_add_cancel_unit_defines.svh"

module lobac_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lobac_pkg::t_cmd    i_cmd,
    output lobac_pkg::t_stat   o_stat,
    input  logic               i_action,
    input  logic [31:0]        i_order_id,
    input  logic [1:0]         i_order_type,
    input  logic               i_side,
    input  logic signed [31:0] i_price,
    input  logic signed [31:0] i_quantity,
    output logic               o_valid,
    output logic [3:0]         o_status,
    output logic [3:0]         o_queue_position,
    output logic               o_level_removed
);

    localparam int EW = lobac_pkg::EntW;
    localparam int SW = lobac_pkg::SlotW;
    localparam int GW = lobac_pkg::GW;
    localparam int PW = lobac_pkg::PosW;
    localparam int CW = lobac_pkg::CntW;
    localparam int AW = lobac_pkg::RestAW;
    localparam int QW = lobac_pkg::ScW;

    // captured item
    logic               r_action;
    logic [31:0]        r_id;
    logic [1:0]         r_type;
    logic               r_side;
    logic signed [31:0] r_price;
    logic signed [31:0] r_qty;

    // flop state
    logic [lobac_pkg::ORDER_CAPACITY-1:0] r_ent_valid;
    logic [lobac_pkg::NSLOTS-1:0]         r_slot_valid;

    // memories
    logic [31:0]       m_ent_id    [lobac_pkg::ORDER_CAPACITY];
    logic [GW-1:0]     m_ent_ss    [lobac_pkg::ORDER_CAPACITY];
    logic [PW-1:0]     m_ent_pos   [lobac_pkg::ORDER_CAPACITY];
    logic [31:0]       m_slot_price[lobac_pkg::NSLOTS];
    logic [CW-1:0]     m_slot_cnt  [lobac_pkg::NSLOTS];
    lobac_pkg::t_rest  m_rest      [lobac_pkg::NSLOTS * lobac_pkg::LEVEL_DEPTH];

    // registered read data
    logic [31:0]      r_eid_q;
    logic [31:0]      r_sp_q;
    logic [GW-1:0]    r_ss_q;
    logic [PW-1:0]    r_epos_q;
    logic [CW-1:0]    r_cnt_q;
    lobac_pkg::t_rest r_rest_q;

    // scan state
    logic [QW-1:0] r_sc;
    logic [QW-1:0] r_pidx;
    logic          r_pv;
    logic          r_hit;
    logic [EW-1:0] r_hit_idx;
    logic          r_fe_ok;
    logic [EW-1:0] r_fe;
    logic          r_lvl_hit;
    logic [SW-1:0] r_lvl;
    logic          r_fs_ok;
    logic [SW-1:0] r_fs;
    logic [PW-1:0] r_p;

    // output registers
    logic       r_o_valid;
    logic [3:0] r_o_status;
    logic [3:0] r_o_qpos;
    logic       r_o_lrem;

    logic [QW-1:0] scan_lim;
    logic          scan_issue;
    logic [GW-1:0] g_add;
    logic [GW-1:0] g_sel;
    logic [CW-1:0] eff_cnt;
    logic [PW-1:0] add_pos;
    logic [CW-1:0] cnt_dec;
    logic [GW-1:0] g_scan;
    logic          ev_scan;
    logic          sv_scan;

    // derived addresses and counts
    always_comb begin
        scan_lim   = i_cmd.scan_slot ? QW'(lobac_pkg::LEVEL_SLOTS)
                                     : QW'(lobac_pkg::ORDER_CAPACITY);
        scan_issue = i_cmd.scan && (r_sc < scan_lim);
        g_add      = {r_side, (r_lvl_hit ? r_lvl : r_fs)};
        g_sel      = (r_action == lobac_pkg::ACT_CANCEL) ? r_ss_q : g_add;
        eff_cnt    = r_lvl_hit ? r_cnt_q : '0;
        add_pos    = eff_cnt[PW-1:0];
        cnt_dec    = r_cnt_q - CW'(1);
        g_scan     = {r_side, r_pidx[SW-1:0]};
        ev_scan    = r_ent_valid[r_pidx[EW-1:0]];
        sv_scan    = r_slot_valid[g_scan];
    end

    // status toward the controller
    always_comb begin
        o_stat.is_cancel = (r_action == lobac_pkg::ACT_CANCEL);
        o_stat.bad_type  = (r_type != lobac_pkg::TYPE_LIMIT);
        o_stat.bad_qty   = (r_qty <= 0);
        o_stat.bad_price = (r_price <= 0);
        o_stat.scan_done = (r_sc == scan_lim) && !r_pv;
        o_stat.id_hit    = r_hit;
        o_stat.free_ent  = r_fe_ok;
        o_stat.lvl_hit   = r_lvl_hit;
        o_stat.free_slot = r_fs_ok;
        o_stat.lvl_full  = r_lvl_hit && (r_cnt_q >= CW'(lobac_pkg::LEVEL_DEPTH));
        o_stat.stale     = !r_slot_valid[r_ss_q] || (CW'(r_epos_q) >= r_cnt_q)
                           || (r_cnt_q > CW'(lobac_pkg::LEVEL_DEPTH));
        o_stat.more      = ((CW'(r_p) + CW'(1)) < r_cnt_q);
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_id     <= i_order_id;
            r_type   <= i_order_type;
            r_side   <= i_side;
            r_price  <= i_price;
            r_qty    <= i_quantity;
        end
    end

    // scan counter and search results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc      <= '0;
            r_pv      <= 1'b0;
            r_hit     <= 1'b0;
            r_fe_ok   <= 1'b0;
            r_lvl_hit <= 1'b0;
            r_fs_ok   <= 1'b0;
        end else if (i_cmd.load || i_cmd.scan_clr) begin
            r_sc      <= '0;
            r_pv      <= 1'b0;
            r_lvl_hit <= 1'b0;
            r_fs_ok   <= 1'b0;
            if (i_cmd.load) begin
                r_hit   <= 1'b0;
                r_fe_ok <= 1'b0;
            end
        end else if (i_cmd.scan) begin
            r_pv   <= scan_issue;
            r_pidx <= r_sc;
            if (scan_issue) begin
                r_sc <= r_sc + QW'(1);
            end
            if (r_pv && !i_cmd.scan_slot) begin
                if (ev_scan && (r_eid_q == r_id) && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_pidx[EW-1:0];
                end
                if (!ev_scan && !r_fe_ok) begin
                    r_fe_ok <= 1'b1;
                    r_fe    <= r_pidx[EW-1:0];
                end
            end
            if (r_pv && i_cmd.scan_slot) begin
                if (sv_scan && !r_lvl_hit && (r_sp_q == r_price)) begin
                    r_lvl_hit <= 1'b1;
                    r_lvl     <= r_pidx[SW-1:0];
                end
                if (!sv_scan && !r_fs_ok) begin
                    r_fs_ok <= 1'b1;
                    r_fs    <= r_pidx[SW-1:0];
                end
            end
        end
    end

    // index and level valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid  <= '0;
            r_slot_valid <= '0;
        end else begin
            if (i_cmd.wr_add) begin
                r_ent_valid[r_fe]   <= 1'b1;
                r_slot_valid[g_add] <= 1'b1;
            end
            if (i_cmd.clr_ent) begin
                r_ent_valid[r_hit_idx] <= 1'b0;
            end
            if (i_cmd.fin && (cnt_dec == '0)) begin
                r_slot_valid[r_ss_q] <= 1'b0;
            end
        end
    end

    // index id store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_add) begin
            m_ent_id[r_fe] <= r_id;
        end
        r_eid_q <= m_ent_id[r_sc[EW-1:0]];
    end

    // index location store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_add) begin
            m_ent_ss[r_fe] <= g_add;
        end
        if (i_cmd.rd_ent) begin
            r_ss_q <= m_ent_ss[r_hit_idx];
        end
    end

    // index position store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_add) begin
            m_ent_pos[r_fe] <= add_pos;
        end else if (i_cmd.sh_wr) begin
            m_ent_pos[r_rest_q.ent] <= r_p;
        end
        if (i_cmd.rd_ent) begin
            r_epos_q <= m_ent_pos[r_hit_idx];
        end
    end

    // level price store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_add && !r_lvl_hit) begin
            m_slot_price[g_add] <= r_price;
        end
        r_sp_q <= m_slot_price[{r_side, r_sc[SW-1:0]}];
    end

    // level count store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_add) begin
            m_slot_cnt[g_add] <= CW'(add_pos) + CW'(1);
        end else if (i_cmd.fin) begin
            m_slot_cnt[r_ss_q] <= cnt_dec;
        end
        if (i_cmd.rd_cnt) begin
            r_cnt_q <= m_slot_cnt[g_sel];
        end
    end

    // resting queues
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_add) begin
            m_rest[{g_add, add_pos}] <= '{ent: r_fe, qty: r_qty, id: r_id};
        end else if (i_cmd.sh_wr) begin
            m_rest[{r_ss_q, r_p}] <= r_rest_q;
        end
        if (i_cmd.sh_rd) begin
            r_rest_q <= m_rest[AW'({r_ss_q, r_p}) + AW'(1)];
        end
    end

    // shift pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_ent) begin
            r_p <= r_epos_q;
        end else if (i_cmd.sh_wr) begin
            r_p <= r_p + PW'(1);
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_o_status <= i_cmd.code;
            r_o_qpos   <= i_cmd.wr_add ? 4'(add_pos) : 4'd0;
            r_o_lrem   <= i_cmd.fin && (cnt_dec == '0);
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_queue_position = r_o_qpos;
    assign o_level_removed  = r_o_lrem;

    // checks
    `LOBAC_ASSERT_NOW(a_lrem_ok, i_clk, i_rst_n, o_valid && o_level_removed, o_status == lobac_pkg::ST_OK, "level freed on a failed item")
    `LOBAC_ASSERT_NOW(a_shift_in_range, i_clk, i_rst_n, i_cmd.sh_wr, (CW'(r_p) + CW'(1)) < r_cnt_q, "queue shift past level count")
    `LOBAC_ASSERT_NEXT(a_add_level_live, i_clk, i_rst_n, i_cmd.wr_add, r_slot_valid[g_add] && r_ent_valid[r_fe], "add left level or index entry free")

endmodule
